// File: hdl/word_tokenizer_lowercase_top_assert.svh
// Assertion macros shared by the word tokenizer checker.
// Include by bare file name; the macros need nothing else.
`ifndef WORD_TOKENIZER_LOWERCASE_TOP_ASSERT_SVH
`define WORD_TOKENIZER_LOWERCASE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define WTL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WTL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/wtl_pkg.sv
// Package for the lowercase word tokenizer: request and result types,
// character constants and the byte classification functions. No dependencies.
package wtl_pkg;

  localparam logic [7:0] APOSTROPHE_CHAR = 8'h27;
  localparam logic [7:0] PERIOD_CHAR     = 8'h2E;
  localparam logic [7:0] CASE_OFFSET     = 8'd32;

  // Result kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // One request can cause up to four results.
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_req_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] token_byte;
    logic       last_result;
  } result_t;

  // Results of one request, packed from entry zero upward.
  typedef struct packed {
    result_t [NUM_SLOTS-1:0] entry;
    logic [CNT_W-1:0]        count;
  } burst_t;

  // Outcome of classifying one byte.
  typedef struct packed {
    logic       emit;
    logic       result_kind;
    logic [7:0] byte_val;
    logic       token_open;
  } cls_out_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return is_upper(c) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  // Classify byte c with nn following bytes present (n1, n2), the byte
  // before it (pb, valid when pv) and the current open-token flag.
  function automatic cls_out_t classify(input logic [7:0] c, input logic [1:0] nn,
                                        input logic [7:0] n1, input logic [7:0] n2,
                                        input logic [7:0] pb, input logic pv,
                                        input logic topen);
    cls_out_t r;
    logic     keep;
    r.emit        = 1'b0;
    r.result_kind = KIND_BYTE;
    r.byte_val    = 8'd0;
    r.token_open  = topen;
    keep          = 1'b0;
    if (is_space(c)) begin
      if (topen) begin
        r.emit        = 1'b1;
        r.result_kind = KIND_END;
        r.token_open  = 1'b0;
      end
    end else if (is_punct(c)) begin
      keep = (c == APOSTROPHE_CHAR && pv && nn != 2'd0 && is_alpha(pb) && is_alpha(n1)) ||
             (c == PERIOD_CHAR && pv && nn == 2'd2 && is_alnum(pb) && is_upper(n1) &&
              n2 == PERIOD_CHAR);
      if (keep) begin
        r.emit       = 1'b1;
        r.byte_val   = c;
        r.token_open = 1'b1;
      end else if (topen) begin
        r.emit        = 1'b1;
        r.result_kind = KIND_END;
        r.token_open  = 1'b0;
      end
    end else begin
      r.emit       = 1'b1;
      r.byte_val   = is_upper(c) ? c + CASE_OFFSET : c;
      r.token_open = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: hdl/wtl_core.sv
// Tokenizer core: input register, window state and per-request classification.
// Depends on wtl_pkg; hands a burst of results to the result buffer.
module wtl_core import wtl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      text_valid,
  output logic      text_stall,
  input  text_req_t text,
  output logic      burst_valid,
  input  logic      burst_ready,
  output burst_t    burst
);

  // Input register.
  logic      in_full;
  text_req_t in_req;

  // Window state.
  logic [7:0] prior_byte;
  logic       prior_valid;
  logic [7:0] la0;
  logic [7:0] la1;
  logic [1:0] held_count;
  logic       token_open;

  logic       have_two;
  logic       have_one;
  logic       two_left;
  logic       eot;
  logic [7:0] cur;
  logic [7:0] r0;
  logic [7:0] pb_a;
  logic       pv_a;
  logic       topen_a;
  cls_out_t   slot_a;
  cls_out_t   slot_b;
  cls_out_t   slot_c;
  logic       close_d;
  result_t [NUM_SLOTS-1:0] res;
  logic    [NUM_SLOTS-1:0] em;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] last_idx;
  burst_t     burst_next;
  logic       consume;

  assign eot      = in_req.end_of_text;
  assign cur      = in_req.text_byte;
  assign have_two = held_count[1];
  assign have_one = (held_count == 2'd1);
  assign two_left = have_two | have_one;
  assign r0       = have_two ? la1 : (have_one ? la0 : cur);

  // Oldest byte is classified once two bytes follow it.
  assign slot_a  = classify(la0, 2'd2, la1, cur, prior_byte, prior_valid, token_open);
  assign pb_a    = have_two ? la0 : prior_byte;
  assign pv_a    = have_two | prior_valid;
  assign topen_a = have_two ? slot_a.token_open : token_open;

  // End of text flushes the remaining bytes with the lookahead that exists.
  assign slot_b = classify(r0, two_left ? 2'd1 : 2'd0, two_left ? cur : 8'd0, 8'd0,
                           pb_a, pv_a, topen_a);
  assign slot_c = classify(cur, 2'd0, 8'd0, 8'd0, r0, 1'b1, slot_b.token_open);
  assign close_d = two_left ? slot_c.token_open : slot_b.token_open;

  // Gather the raw results with their enables.
  always_comb begin
    em[0]  = have_two & slot_a.emit;
    em[1]  = eot & slot_b.emit;
    em[2]  = eot & two_left & slot_c.emit;
    em[3]  = eot & close_d;
    res[0] = '{result_kind: slot_a.result_kind, token_byte: slot_a.byte_val,
               last_result: 1'b0};
    res[1] = '{result_kind: slot_b.result_kind, token_byte: slot_b.byte_val,
               last_result: 1'b0};
    res[2] = '{result_kind: slot_c.result_kind, token_byte: slot_c.byte_val,
               last_result: 1'b0};
    res[3] = '{result_kind: KIND_END, token_byte: 8'd0, last_result: 1'b0};
  end

  // Pack the emitted results to the front and flag the final one.
  always_comb begin
    burst_next = '0;
    cnt        = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (em[i]) begin
        burst_next.entry[cnt[SLOT_W-1:0]] = res[i];
        cnt = cnt + CNT_W'(1);
      end
    end
    last_idx = cnt - CNT_W'(1);
    if (cnt != '0) begin
      burst_next.entry[last_idx[SLOT_W-1:0]].last_result = 1'b1;
    end
    burst_next.count = cnt;
  end

  // A request with no results never waits on the buffer.
  assign consume     = in_full && (burst_next.count == '0 || burst_ready);
  assign burst_valid = consume && burst_next.count != '0;
  assign burst       = burst_next;
  assign text_stall  = in_full && !consume;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (text_valid && !text_stall) begin
      in_full <= 1'b1;
    end else if (consume) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      in_req <= text;
    end
  end

  // Window state update when the request is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_byte  <= 8'd0;
      prior_valid <= 1'b0;
      la0         <= 8'd0;
      la1         <= 8'd0;
      held_count  <= 2'd0;
      token_open  <= 1'b0;
    end else if (consume) begin
      if (eot) begin
        prior_byte  <= 8'd0;
        prior_valid <= 1'b0;
        la0         <= 8'd0;
        la1         <= 8'd0;
        held_count  <= 2'd0;
        token_open  <= 1'b0;
      end else if (have_two) begin
        prior_byte  <= la0;
        prior_valid <= 1'b1;
        la0         <= la1;
        la1         <= cur;
        token_open  <= slot_a.token_open;
      end else if (have_one) begin
        la1        <= cur;
        held_count <= 2'd2;
      end else begin
        la0        <= cur;
        held_count <= 2'd1;
      end
    end
  end

endmodule

// File: hdl/wtl_rbuf.sv
// Result buffer: holds a burst, delivers one result per cycle if unstalled.
// Depends on wtl_pkg; fed by wtl_core.
module wtl_rbuf import wtl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    burst_valid,
  output logic    burst_ready,
  input  burst_t  burst,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  result_t [NUM_SLOTS-1:0] entries;
  logic [CNT_W-1:0]        left;
  logic [SLOT_W-1:0]       rd;
  logic                    fire;

  assign result_valid = (left != '0);
  assign result       = entries[rd];
  assign fire         = result_valid && !result_stall;
  assign burst_ready  = (left == '0) || (left == CNT_W'(1) && fire);

  // Count and read pointer; a new burst takes over once the last one drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      rd   <= '0;
    end else if (burst_valid && burst_ready) begin
      left <= burst.count;
      rd   <= '0;
    end else if (fire) begin
      left <= left - CNT_W'(1);
      rd   <= rd + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (burst_valid && burst_ready) begin
      entries <= burst.entry;
    end
  end

endmodule

// File: hdl/word_tokenizer_lowercase_top.sv
// Lowercase word tokenizer, top level. Depends on wtl_pkg, wtl_core, wtl_rbuf.
// Registers: the core's input register, then the result buffer.
// Throughput, with no receiver stall: one request per cycle while each
// request yields at most one result; an end-of-text request yields up to
// four, one per cycle from the result buffer; input stalls until it has room.
// Reset (rst, synchronous) empties both registers and clears the window.
module word_tokenizer_lowercase_top import wtl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      text_valid,
  output logic      text_stall,
  input  text_req_t text,
  output logic      result_valid,
  input  logic      result_stall,
  output result_t   result
);

  logic   burst_valid;
  logic   burst_ready;
  burst_t burst;

  // Classification of each request.
  wtl_core u_core (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text        (text),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst)
  );

  // Delivery of results.
  wtl_rbuf u_rbuf (
    .clk          (clk),
    .rst          (rst),
    .burst_valid  (burst_valid),
    .burst_ready  (burst_ready),
    .burst        (burst),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: hdl/wtl_checker.sv
// Port-level checker for the word tokenizer, bound to the top level.
// Depends on wtl_pkg and word_tokenizer_lowercase_top_assert.svh.
`include "word_tokenizer_lowercase_top_assert.svh"

module wtl_checker import wtl_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      text_valid,
  input logic      text_stall,
  input text_req_t text,
  input logic      result_valid,
  input logic      result_stall,
  input result_t   result
);

  // A stalled request stays offered and unchanged.
  `WTL_ASSERT_NEXT(a_req_held, clk, rst, text_valid && text_stall,
                   text_valid && $stable(text), "request dropped or changed while stalled")

  // A stalled result stays offered and unchanged.
  `WTL_ASSERT_NEXT(a_valid_held, clk, rst, result_valid && result_stall, result_valid,
                   "result dropped while stalled")
  `WTL_ASSERT_NEXT(a_data_held, clk, rst, result_valid && result_stall, $stable(result),
                   "result changed while stalled")

  // End markers carry a zero byte, and token bytes are never upper case.
  `WTL_ASSERT_SAME(a_end_zero, clk, rst, result_valid && result.result_kind == KIND_END,
                   result.token_byte == 8'd0, "end marker with nonzero byte")
  `WTL_ASSERT_SAME(a_lowercase, clk, rst, result_valid && result.result_kind == KIND_BYTE,
                   !(result.token_byte >= 8'h41 && result.token_byte <= 8'h5A),
                   "upper case byte delivered")

endmodule

bind word_tokenizer_lowercase_top wtl_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .text_valid   (text_valid),
  .text_stall   (text_stall),
  .text         (text),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// File: tb/sv/tb.sv
// Self-checking testbench for word_tokenizer_lowercase_top.
// It predicts token bytes and end-of-token markers for every text request and
// checks each result in order. It depends on wtl_pkg and the tokenizer RTL.
module tb import wtl_pkg::*; ();

  localparam int CLK_HALF   = 5;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_WAIT = 8;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      text_valid   = 1'b0;
  logic      text_stall;
  text_req_t text         = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  result_t   result;

  // Predictor state: byte before the next one to classify, the held window
  // and the open-word flag.
  logic [7:0] prev_char;
  logic       prev_known;
  logic [7:0] window [2];
  int         held;
  logic       in_word;

  result_t    expected_results [$];
  result_t    request_results [$];
  logic [7:0] text_buf [$];

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  int  stall_left     = 0;
  bit  idle_enable    = 1'b1;

  word_tokenizer_lowercase_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text         (text),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #CLK_HALF clk = ~clk;

  // Character classes, ASCII rules.
  function automatic bit is_blank(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
  endfunction

  function automatic bit is_capital(input logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return is_capital(c) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit is_letter_or_digit(input logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic bit is_mark(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  task automatic reset_window();
    prev_char  = 8'd0;
    prev_known = 1'b0;
    window[0]  = 8'd0;
    window[1]  = 8'd0;
    held       = 0;
    in_word    = 1'b0;
  endtask

  task automatic add_result(input logic kind, input logic [7:0] b);
    result_t r;
    r.result_kind = kind;
    r.token_byte  = b;
    r.last_result = 1'b0;
    request_results.push_back(r);
  endtask

  task automatic close_word();
    if (in_word) begin
      add_result(KIND_END, 8'd0);
      in_word = 1'b0;
    end
  endtask

  // Decide one byte given how many following bytes are known.
  task automatic decide_char(input logic [7:0] c, input int nn,
                             input logic [7:0] n1, input logic [7:0] n2);
    bit keep;
    keep = 1'b0;
    if (is_blank(c)) begin
      close_word();
    end else if (is_mark(c)) begin
      if (c == APOSTROPHE_CHAR && prev_known && nn >= 1 &&
          is_letter(prev_char) && is_letter(n1))
        keep = 1'b1;
      else if (c == PERIOD_CHAR && prev_known && nn >= 2 &&
               is_letter_or_digit(prev_char) && is_capital(n1) && n2 == PERIOD_CHAR)
        keep = 1'b1;
      if (keep) begin
        add_result(KIND_BYTE, c);
        in_word = 1'b1;
      end else begin
        close_word();
      end
    end else begin
      add_result(KIND_BYTE, is_capital(c) ? c + CASE_OFFSET : c);
      in_word = 1'b1;
    end
    prev_char  = c;
    prev_known = 1'b1;
  endtask

  // Work out the results of one accepted request and queue them.
  task automatic predict_tokens(input logic [7:0] b, input logic eot);
    logic [7:0] q [3];
    int         n;
    result_t    r;
    n = 0;
    request_results.delete();
    for (int i = 0; i < held; i++) begin
      q[n] = window[i];
      n++;
    end
    q[n] = b;
    n++;
    if (n == 3) begin
      decide_char(q[0], 2, q[1], q[2]);
      q[0] = q[1];
      q[1] = q[2];
      n    = 2;
    end
    if (eot) begin
      if (n == 2) begin
        decide_char(q[0], 1, q[1], 8'd0);
        decide_char(q[1], 0, 8'd0, 8'd0);
      end else begin
        decide_char(q[0], 0, 8'd0, 8'd0);
      end
      close_word();
      reset_window();
    end else begin
      window[0] = (n > 0) ? q[0] : 8'd0;
      window[1] = (n > 1) ? q[1] : 8'd0;
      held      = n;
    end
    if (request_results.size() > 0) begin
      r = request_results.pop_back();
      r.last_result = 1'b1;
      request_results.push_back(r);
    end
    foreach (request_results[i]) expected_results.push_back(request_results[i]);
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Send one request; called and returns at a falling edge.
  task automatic send_request(input logic [7:0] b, input logic eot);
    int gap;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      text_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_valid <= 1'b1;
    text       <= '{text_byte: b, end_of_text: eot};
    @(posedge clk);
    while (text_stall) @(posedge clk);
    predict_tokens(b, eot);
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] r;
    r = 8'($urandom_range(0, 51));
    return (r < 26) ? 8'h41 + r : 8'h47 + r;
  endfunction

  function automatic logic [7:0] random_digit();
    logic [7:0] r;
    r = 8'($urandom_range(0, 9));
    return 8'h30 + r;
  endfunction

  function automatic logic [7:0] random_blank();
    logic [7:0] r;
    r = 8'($urandom_range(0, 5));
    return (r == 5) ? 8'd32 : 8'd9 + r;
  endfunction

  // Uniform over all 32 punctuation codes.
  function automatic logic [7:0] random_mark();
    logic [7:0] r;
    r = 8'($urandom_range(0, 31));
    if (r < 15)      return 8'd33 + r;
    else if (r < 22) return 8'd58 + (r - 15);
    else if (r < 28) return 8'd91 + (r - 22);
    else             return 8'd123 + (r - 28);
  endfunction

  // Build one text from words, contractions, abbreviations, separators and
  // the odd arbitrary byte.
  task automatic build_text();
    int target;
    text_buf.delete();
    target = $urandom_range(1, 24);
    while (text_buf.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 6)) text_buf.push_back(random_letter());
        4: repeat ($urandom_range(1, 4)) text_buf.push_back(random_digit());
        5: begin
          repeat ($urandom_range(1, 4)) text_buf.push_back(random_letter());
          text_buf.push_back(APOSTROPHE_CHAR);
          repeat ($urandom_range(1, 3)) text_buf.push_back(random_letter());
        end
        6: begin
          text_buf.push_back($urandom_range(0, 1) ? random_letter() : random_digit());
          text_buf.push_back(PERIOD_CHAR);
          text_buf.push_back(8'h41 + 8'($urandom_range(0, 25)));
          text_buf.push_back(PERIOD_CHAR);
        end
        7: repeat ($urandom_range(1, 3)) text_buf.push_back(random_blank());
        8: text_buf.push_back(random_mark());
        default: text_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic send_random_texts(input int item_total);
    int sent;
    sent = 0;
    while (sent < item_total) begin
      build_text();
      foreach (text_buf[i]) send_request(text_buf[i], i == text_buf.size() - 1);
      sent += text_buf.size();
    end
  endtask

  // Contractions, abbreviations and end of text with 0, 1 and 2 held bytes.
  task automatic test_word_rules();
    send_string("x");
    send_string("Q'z");
    send_string("9.K.");
    send_string("ab");
  endtask

  // Byte extremes, control and high bytes, every whitespace code and a
  // stray apostrophe. The first text ends with four results at once.
  task automatic test_char_classes();
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h7F, 1'b1);
    send_request("M", 1'b0);
    send_request(8'd9, 1'b0);
    send_request("n", 1'b0);
    send_request(8'd10, 1'b0);
    send_request(8'd11, 1'b0);
    send_request(8'd12, 1'b0);
    send_request(8'd13, 1'b0);
    send_request(8'd32, 1'b0);
    send_request(APOSTROPHE_CHAR, 1'b1);
  endtask

  task automatic test_random_traffic();
    send_random_texts(170);
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_full_rate();
    idle_enable = 1'b0;
    send_random_texts(30);
  endtask

  // Receiver stalls come in random bursts while idling is enabled.
  always @(negedge clk) begin
    if (rst || !idle_enable) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(1, 18) - 1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0b byte=%02h last=%0b",
                                  result.result_kind, result.token_byte,
                                  result.last_result));
      end else begin
        want = expected_results.pop_front();
        if (result.result_kind !== want.result_kind)
          report_mismatch($sformatf("result_kind got %0b want %0b",
                                    result.result_kind, want.result_kind));
        if (result.token_byte !== want.token_byte)
          report_mismatch($sformatf("token_byte got %02h want %02h",
                                    result.token_byte, want.token_byte));
        if (result.last_result !== want.last_result)
          report_mismatch($sformatf("last_result got %0b want %0b",
                                    result.last_result, want.last_result));
      end
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    reset_window();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_word_rules();
    test_char_classes();
    test_random_traffic();
    test_full_rate();
    text_valid <= 1'b0;

    // Drain the remaining results, then give stray results time to show.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
